// ===== design/lurg_pkg.sv =====
// Shared constants, codes and types of the uniform range generator.
package lurg_pkg;

  localparam int ACC_W    = 84;   // fixed-point accumulator, two's complement
  localparam int FRAC_W   = 46;   // fraction bits of the accumulator
  localparam int SIG_W    = 53;   // significant bits kept by each rounding
  localparam int W_W      = 33;   // range width operand
  localparam int FR_W     = 47;   // seed fraction operand
  localparam int CNT_W    = 7;

  localparam logic [31:0] LCG_MULT      = 32'd69069;
  localparam logic [31:0] ZERO_SEED_SUB = 32'd259341593;
  localparam logic [31:0] DIV_DEN       = 32'hFFFF_FFFF;

  localparam logic [ACC_W-1:0] ONE_FX  = ACC_W'(1) << FRAC_W;
  localparam logic [ACC_W-1:0] HALF_FX = ACC_W'(1) << (FRAC_W + 31);

  localparam logic signed [32:0] I32_MAX_X = 33'sh0_7FFF_FFFF;
  localparam logic signed [32:0] I32_MIN_X = 33'sh1_8000_0000;

  localparam logic OP_SIGNED   = 1'b0;
  localparam logic OP_UNSIGNED = 1'b1;

  // scaling branch
  localparam logic [1:0] BR_LOW  = 2'd0;  // high bound below the largest value
  localparam logic [1:0] BR_HIGH = 2'd1;  // low bound above the smallest value
  localparam logic [1:0] BR_FULL = 2'd2;  // full 32-bit range

  typedef struct packed {
    logic                 empty;
    logic [1:0]           br;
    logic signed [32:0]   lo;
    logic signed [32:0]   hi;
    logic signed [32:0]   add;
    logic [W_W-1:0]       w;
    logic [FR_W-1:0]      fr;
    logic [31:0]          seed;
    logic                 flip;
  } lurg_job_t;

endpackage

// ===== design/lurg_in_if.sv =====
// Input channel: request word of the range generator.
interface lurg_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic               use_given_seed;
  logic signed [31:0] seed_in;
  logic [31:0]        range_low;
  logic [31:0]        range_high;

  modport source (output valid, operation, use_given_seed, seed_in, range_low, range_high,
                  input ready);
  modport sink   (input valid, operation, use_given_seed, seed_in, range_low, range_high,
                  output ready);
endinterface

// ===== design/lurg_out_if.sv =====
// Output channel: result word of the range generator.
interface lurg_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        value;
  logic signed [31:0] seed_out;

  modport source (output valid, value, seed_out, input ready);
  modport sink   (input valid, value, seed_out, output ready);
endinterface

// ===== design/lurg_lcg.sv =====
// Seed advance (x*69069+1) and the 47-bit fraction taken from the new seed.
module lurg_lcg (
  input  logic [31:0]               seed_i,
  output logic [31:0]               next_o,
  output logic [lurg_pkg::FR_W-1:0] fr_o
);
  import lurg_pkg::*;

  logic [31:0] base;
  logic [63:0] prod;
  logic [22:0] frac;
  logic [23:0] frac_p1;

  assign base    = (seed_i == 32'd0) ? ZERO_SEED_SUB : seed_i;
  assign prod    = base * LCG_MULT;
  assign next_o  = prod[31:0] + 32'd1;
  assign frac    = next_o[31:9];
  assign frac_p1 = {1'b0, frac} + 24'd1;
  assign fr_o    = {frac_p1, 23'd0} + {24'd0, frac};
endmodule

// ===== design/lurg_engine.sv =====
// Sequenced fixed-point engine: multiply, add, round-to-53, divide, floor, clamp.
module lurg_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  lurg_pkg::lurg_job_t job_i,
  input  logic                out_free_i,
  output logic                ready_o,
  output logic                done_o,
  output logic [31:0]         value_o,
  output logic [31:0]         seed_o
);
  import lurg_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_RND_I = 4'd2;
  localparam logic [3:0] S_RND_R = 4'd3;
  localparam logic [3:0] S_RND_L = 4'd4;
  localparam logic [3:0] S_NEXT  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_FLOOR = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  // what follows the current rounding
  localparam logic [2:0] P_P   = 3'd0;  // product rounded, add low term
  localparam logic [2:0] P_R   = 3'd1;  // sum rounded, pick branch
  localparam logic [2:0] P_R2  = 3'd2;  // plus one rounded
  localparam logic [2:0] P_X   = 3'd3;  // offset sum rounded, divide
  localparam logic [2:0] P_T   = 3'd4;  // quotient rounded, subtract offset
  localparam logic [2:0] P_U   = 3'd5;  // difference rounded
  localparam logic [2:0] P_FIN = 3'd6;  // floor step rounded

  logic [3:0]       state_q, state_d;
  logic [2:0]       phase_q, phase_d;
  lurg_job_t        job_q, job_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0] mag_q, mag_d;
  logic             neg_q, neg_d;
  logic             grd_q, grd_d;
  logic             stk_q, stk_d;
  logic [CNT_W-1:0] sh_q, sh_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W_W-1:0]   w_q, w_d;

  // truncation and clamp
  logic             fin_neg;
  logic [ACC_W-1:0] fin_mag;
  logic [37:0]      fin_ip;
  logic signed [32:0] fin_v;
  logic signed [32:0] fin_c;

  assign fin_neg = acc_q[ACC_W-1];
  assign fin_mag = fin_neg ? (ACC_W'(0) - acc_q) : acc_q;
  assign fin_ip  = fin_mag[ACC_W-1:FRAC_W];

  always_comb begin
    if (fin_neg) begin
      if (fin_ip > 38'd2147483648) fin_v = I32_MIN_X;
      else fin_v = 33'sd0 - $signed({1'b0, fin_ip[31:0]});
    end else begin
      if (fin_ip > 38'd2147483647) fin_v = I32_MAX_X;
      else fin_v = $signed({1'b0, fin_ip[31:0]});
    end
    fin_c = fin_v;
    if (!job_q.empty) begin
      if (fin_v < job_q.lo) fin_c = job_q.lo;
      else if (fin_v > job_q.hi) fin_c = job_q.hi;
    end
  end

  assign value_o = fin_c[31:0] ^ {job_q.flip, 31'd0};
  assign seed_o  = job_q.seed;
  assign ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    job_d   = job_q;
    acc_d   = acc_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    grd_d   = grd_q;
    stk_d   = stk_q;
    sh_d    = sh_q;
    cnt_d   = cnt_q;
    w_d     = w_q;
    done_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          job_d = job_i;
          if (job_i.empty) begin
            acc_d   = {{(ACC_W-33-FRAC_W){job_i.lo[32]}}, job_i.lo, {FRAC_W{1'b0}}};
            state_d = S_FIN;
          end else begin
            acc_d   = '0;
            w_d     = job_i.w;
            cnt_d   = '0;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        // MSB-first shift and add of range width times fraction
        acc_d = {acc_q[ACC_W-2:0], 1'b0} + (w_q[W_W-1] ? ACC_W'(job_q.fr) : '0);
        w_d   = {w_q[W_W-2:0], 1'b0};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(W_W-1)) begin
          phase_d = P_P;
          state_d = S_RND_I;
        end
      end
      S_RND_I: begin
        neg_d   = acc_q[ACC_W-1];
        mag_d   = acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
        sh_d    = '0;
        grd_d   = 1'b0;
        stk_d   = 1'b0;
        state_d = S_RND_R;
      end
      S_RND_R: begin
        if (|mag_q[ACC_W-1:SIG_W]) begin
          stk_d = stk_q | grd_q;
          grd_d = mag_q[0];
          mag_d = {1'b0, mag_q[ACC_W-1:1]};
          sh_d  = sh_q + CNT_W'(1);
        end else begin
          // nearest, ties to even
          mag_d   = mag_q + ACC_W'(grd_q & (stk_q | mag_q[0]));
          state_d = S_RND_L;
        end
      end
      S_RND_L: begin
        if (sh_q != '0) begin
          mag_d = {mag_q[ACC_W-2:0], 1'b0};
          sh_d  = sh_q - CNT_W'(1);
        end else begin
          acc_d   = neg_q ? (ACC_W'(0) - mag_q) : mag_q;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        case (phase_q)
          P_P: begin
            acc_d   = acc_q + {{(ACC_W-33-FRAC_W){job_q.add[32]}}, job_q.add, {FRAC_W{1'b0}}};
            phase_d = P_R;
            state_d = S_RND_I;
          end
          P_R: begin
            case (job_q.br)
              BR_LOW: state_d = S_FLOOR;
              BR_HIGH: begin
                acc_d   = acc_q + ONE_FX;
                phase_d = P_R2;
                state_d = S_RND_I;
              end
              default: begin
                acc_d   = acc_q + HALF_FX;
                phase_d = P_X;
                state_d = S_RND_I;
              end
            endcase
          end
          P_X: begin
            // acc keeps A, mag carries the running remainder
            mag_d   = acc_q;
            state_d = S_DIV;
          end
          P_T: begin
            acc_d   = acc_q - HALF_FX;
            phase_d = P_U;
            state_d = S_RND_I;
          end
          P_FIN:   state_d = S_FIN;
          default: state_d = S_FLOOR;
        endcase
      end
      S_DIV: begin
        // A*2^32/(2^32-1) = A + A/(2^32-1); fold 32-bit limbs since 2^32 = 1 mod den
        if (|mag_q[ACC_W-1:32]) begin
          acc_d = acc_q + (mag_q >> 32);
          mag_d = (mag_q >> 32) + ACC_W'(mag_q[31:0]);
        end else begin
          // remainder equal to den is one more quotient; else low bit is sticky
          if (mag_q[31:0] == DIV_DEN) acc_d = acc_q + ACC_W'(1);
          else acc_d = acc_q | ACC_W'(mag_q[31:0] != 32'd0);
          phase_d = P_T;
          state_d = S_RND_I;
        end
      end
      S_FLOOR: begin
        if (acc_q[ACC_W-1]) begin
          acc_d   = acc_q - ONE_FX;
          phase_d = P_FIN;
          state_d = S_RND_I;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= P_P;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    acc_q <= acc_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    grd_q <= grd_d;
    stk_q <= stk_d;
    sh_q  <= sh_d;
    cnt_q <= cnt_d;
    w_q   <= w_d;
  end
endmodule

// ===== design/lcg_uniform_range_generator_top.sv =====
// Top level of the uniform range generator on the 69069 congruential seed.
//
//  channel | dir | word
//  in_i    | in  | operation, use_given_seed, seed_in, range_low, range_high
//  out_o   | out | value, seed_out
//
// One word at a time: in_i.ready is high only while the engine is idle.
// A word with low >= high goes straight to the engine's last step and from
// there to the output register. Otherwise the 33-step shift-add multiplier
// and the 53-bit roundings set the time, each rounding taking longer the
// more bits it drops; the low and high branches make two to four roundings,
// the full-range branch five or six plus the limb-folding divide steps.
// Reset clears the stored seed to zero and the engine to idle.
// A finished result moves to the output register once it is free; until then
// the engine waits in its last step, and it takes a new word when back to idle.
module lcg_uniform_range_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  lurg_in_if.sink     in_i,
  lurg_out_if.source  out_o
);
  import lurg_pkg::*;

  logic        accept;
  logic        flip;
  logic [31:0] lo32, hi32;
  logic signed [32:0] lo, hi;
  logic        empty;
  logic [31:0] cur_seed;
  logic [31:0] next_seed;
  logic [FR_W-1:0] fr;
  logic signed [33:0] w_wide;
  lurg_job_t   job;

  logic        eng_ready;
  logic        eng_done;
  logic [31:0] eng_value;
  logic [31:0] eng_seed;
  logic        out_free;

  logic [31:0] stored_seed_q, stored_seed_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] value_q;
  logic [31:0] seed_q;

  assign in_i.ready = eng_ready;
  assign accept     = in_i.valid & eng_ready;

  // unsigned mode maps onto the signed rule by flipping the top bit
  assign flip = (in_i.operation == OP_UNSIGNED);
  assign lo32 = in_i.range_low ^ {flip, 31'd0};
  assign hi32 = in_i.range_high ^ {flip, 31'd0};
  assign lo   = $signed({lo32[31], lo32});
  assign hi   = $signed({hi32[31], hi32});
  assign empty = (lo >= hi);

  assign cur_seed = in_i.use_given_seed ? in_i.seed_in : stored_seed_q;

  lurg_lcg u_lcg (
    .seed_i (cur_seed),
    .next_o (next_seed),
    .fr_o   (fr)
  );

  // pick the scaling branch, its width and the added low term
  always_comb begin
    job.empty = empty;
    job.lo    = lo;
    job.hi    = hi;
    job.fr    = fr;
    job.flip  = flip;
    job.seed  = empty ? cur_seed : next_seed;
    if (hi != I32_MAX_X) begin
      job.br  = BR_LOW;
      job.add = lo;
      w_wide  = {hi[32], hi} + 34'sd1 - {lo[32], lo};
    end else if (lo != I32_MIN_X) begin
      job.br  = BR_HIGH;
      job.add = lo - 33'sd1;
      w_wide  = {hi[32], hi} - {lo[32], lo} + 34'sd1;
    end else begin
      job.br  = BR_FULL;
      job.add = lo;
      w_wide  = 34'sh0_FFFF_FFFF;
    end
    job.w = w_wide[W_W-1:0];
  end

  assign out_free = !out_valid_q || out_o.ready;

  lurg_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .job_i      (job),
    .out_free_i (out_free),
    .ready_o    (eng_ready),
    .done_o     (eng_done),
    .value_o    (eng_value),
    .seed_o     (eng_seed)
  );

  // stored seed moves only for words that use it and draw a value
  always_comb begin
    stored_seed_d = stored_seed_q;
    if (accept && !in_i.use_given_seed && !empty) stored_seed_d = next_seed;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (eng_done) out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_seed_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      stored_seed_q <= stored_seed_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_done) begin
      value_q <= eng_value;
      seed_q  <= eng_seed;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.value    = value_q;
  assign out_o.seed_out = seed_q;
endmodule
